// ===== rtl/ebt_pkg.sv =====
package ebt_pkg;

	localparam int SLOTS = 16;
	localparam int MAX_RES = 16;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int RES_W = $clog2(MAX_RES + 1);

	localparam logic [31:0] HALF_RANGE = 32'h7FFF_FFFF;

	localparam logic [2:0] OP_REGISTER  = 3'd0;
	localparam logic [2:0] OP_CANCEL    = 3'd1;
	localparam logic [2:0] OP_CANDIDATE = 3'd2;
	localparam logic [2:0] OP_DISPATCH  = 3'd3;
	localparam logic [2:0] OP_CLEAR     = 3'd4;

	localparam logic [2:0] KIND_NONE        = 3'd0;
	localparam logic [2:0] KIND_GPIO_RISE   = 3'd1;
	localparam logic [2:0] KIND_GPIO_CHANGE = 3'd3;
	localparam logic [2:0] KIND_AFTER       = 3'd5;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_INVALID  = 3'd1;
	localparam logic [2:0] ST_CAPACITY = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_PLATFORM = 3'd4;
	localparam logic [2:0] ST_DROPPED  = 3'd5;
	localparam logic [2:0] ST_NOTHING  = 3'd6;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] source;
		logic [15:0] debounce;
		logic [15:0] body;
		logic [15:0] gen;
		logic [31:0] reg_at;
		logic [31:0] last_fire;
		logic        fired;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	function automatic logic is_gpio(input logic [2:0] k);
		return (k >= KIND_GPIO_RISE) && (k <= KIND_GPIO_CHANGE);
	endfunction

endpackage

// ===== rtl/event_binding_table.sv =====
// channel   signals                          direction
// request   in_valid / in_stall + fields     into the table
// result    out_valid / out_stall + fields   out of the table
//
// one request at a time; in_stall stays high until its last result is registered
// register/cancel scan every slot through the single ram read port, then pick a target
// candidate: read the named slot, then answer; dispatch: walk the slots, one result per pending slot
// (a single nothing-pending result when none is pending)
// unknown op, invalid kind, clear: a single result; a stalled result holds the sequencer
// arst_n clears control, valid and pending bits; ram entries read as zero until written
module event_binding_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [2:0]  event_kind,
	input  logic [15:0] source_id,
	input  logic [15:0] debounce_window,
	input  logic [15:0] body_id,
	input  logic        install_ok,
	input  logic [31:0] time_ms,
	input  logic [15:0] slot_index,
	input  logic [15:0] cand_generation,
	input  logic [31:0] overflow_add,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [3:0]  slot,
	output logic [15:0] tag_generation,
	output logic [15:0] run_body,
	output logic        oneshot_freed,
	output logic [4:0]  active_bindings,
	output logic [31:0] overflow_total,
	output logic        last
);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_PICK, S_CRD, S_CEV, S_DSCAN, S_DEV, S_ONE
	} state_t;

	localparam int SW = ebt_pkg::SLOT_W;
	localparam int CW = ebt_pkg::CNT_W;

	state_t state_q;
	logic [2:0] op_q, kind_q;
	logic [15:0] src_q, deb_q, body_q, cidx_q, cgen_q;
	logic ok_q;
	logic [31:0] t_q, ovf_q, add_q;
	logic [CW-1:0] scan_q, active_q;
	logic [ebt_pkg::RES_W-1:0] nres_q;
	logic live_s1, vld_s1;
	logic [SW-1:0] idx_s1;
	logic mfound_q, ffound_q;
	logic [SW-1:0] midx_q, fidx_q;
	logic [15:0] mgen_q, fgen_q;
	logic [ebt_pkg::SLOTS-1:0] vld_q, pend_q;

	logic out_valid_q, last_q, freed_q;
	logic [2:0] status_q;
	logic [3:0] slot_q;
	logic [15:0] gen_q, rbody_q;

	logic ram_we;
	logic [SW-1:0] ram_waddr, ram_raddr;
	logic [ebt_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

	ebt_pkg::entry_t ent, new_ent, fire_ent, freed_ent;
	logic out_free, ent_match, tgt_found, in_range, drop, more_pend, is_after;
	logic [SW-1:0] scan_idx, cidx_lo, tgt_idx;
	logic [15:0] tgt_gen;
	logic [31:0] dt_reg, dt_fire;

	ebt_ram #(.WIDTH(ebt_pkg::ENTRY_W), .DEPTH(ebt_pkg::SLOTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		out_free = !out_valid_q || !out_stall;
		scan_idx = scan_q[SW-1:0];
		cidx_lo = cidx_q[SW-1:0];
		in_range = cidx_q < 16'(ebt_pkg::SLOTS);
		// never-written entries read as the reset value
		ent = vld_s1 ? ebt_pkg::entry_t'(ram_rdata) : '0;
		ent_match = (ent.kind != ebt_pkg::KIND_NONE) && (ent.source == src_q) &&
			(ebt_pkg::is_gpio(kind_q) ? ebt_pkg::is_gpio(ent.kind) : (ent.kind == kind_q));
		tgt_found = mfound_q || (op_q == ebt_pkg::OP_REGISTER && ffound_q);
		tgt_idx = mfound_q ? midx_q : fidx_q;
		tgt_gen = mfound_q ? mgen_q : fgen_q;
		dt_reg = t_q - ent.reg_at;
		dt_fire = t_q - ent.last_fire;
		drop = (ent.kind == ebt_pkg::KIND_NONE) || (ent.gen != cgen_q) ||
			(dt_reg > ebt_pkg::HALF_RANGE) ||
			((ent.debounce != 16'd0) && ent.fired && (dt_fire < 32'(ent.debounce)));
		more_pend = |((pend_q >> scan_idx) >> 1);
		is_after = ent.kind == ebt_pkg::KIND_AFTER;

		new_ent = '0;
		new_ent.kind = kind_q;
		new_ent.source = src_q;
		new_ent.debounce = deb_q;
		new_ent.body = body_q;
		new_ent.gen = tgt_gen + 16'd1;
		new_ent.reg_at = t_q;
		freed_ent = '0;
		freed_ent.gen = (state_q == S_PICK) ? tgt_gen + 16'd1 : ent.gen + 16'd1;
		fire_ent = ent;
		fire_ent.last_fire = t_q;
		fire_ent.fired = 1'b1;

		ram_we = 1'b0;
		ram_waddr = scan_idx;
		ram_wdata = ebt_pkg::ENTRY_W'(freed_ent);
		ram_raddr = (state_q == S_CRD || state_q == S_CEV) ? cidx_lo : scan_idx;
		unique case (state_q)
			S_PICK: begin
				if (out_free && tgt_found && ok_q) begin
					ram_we = 1'b1;
					ram_waddr = tgt_idx;
					if (op_q == ebt_pkg::OP_REGISTER) begin
						ram_wdata = ebt_pkg::ENTRY_W'(new_ent);
					end
				end
			end
			S_CEV: begin
				if (out_free && in_range && !drop) begin
					ram_we = 1'b1;
					ram_waddr = cidx_lo;
					ram_wdata = ebt_pkg::ENTRY_W'(fire_ent);
				end
			end
			S_DEV: begin
				if (out_free && is_after) begin
					ram_we = 1'b1;
					ram_waddr = idx_s1;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= '0; kind_q <= '0; src_q <= '0; deb_q <= '0; body_q <= '0;
			cidx_q <= '0; cgen_q <= '0; ok_q <= 1'b0; t_q <= '0; ovf_q <= '0; add_q <= '0;
			scan_q <= '0; active_q <= '0; nres_q <= '0;
			live_s1 <= 1'b0; vld_s1 <= 1'b0; idx_s1 <= '0;
			mfound_q <= 1'b0; ffound_q <= 1'b0; midx_q <= '0; fidx_q <= '0;
			mgen_q <= '0; fgen_q <= '0; vld_q <= '0; pend_q <= '0;
			out_valid_q <= 1'b0; last_q <= 1'b0; freed_q <= 1'b0; status_q <= '0;
			slot_q <= '0; gen_q <= '0; rbody_q <= '0;
		end else begin
			vld_s1 <= vld_q[ram_raddr];
			idx_s1 <= ram_raddr;
			live_s1 <= (state_q == S_SCAN) && (scan_q < CW'(ebt_pkg::SLOTS));
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (live_s1) begin
				if (ent_match && !mfound_q) begin
					mfound_q <= 1'b1;
					midx_q <= idx_s1;
					mgen_q <= ent.gen;
				end
				if (ent.kind == ebt_pkg::KIND_NONE && !ffound_q) begin
					ffound_q <= 1'b1;
					fidx_q <= idx_s1;
					fgen_q <= ent.gen;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q <= operation; kind_q <= event_kind; src_q <= source_id;
						deb_q <= debounce_window; body_q <= body_id; ok_q <= install_ok;
						t_q <= time_ms; cidx_q <= slot_index; cgen_q <= cand_generation;
						add_q <= overflow_add;
						scan_q <= '0; nres_q <= '0; mfound_q <= 1'b0; ffound_q <= 1'b0;
						priority case (operation)
							ebt_pkg::OP_REGISTER, ebt_pkg::OP_CANCEL:
								state_q <= (event_kind == ebt_pkg::KIND_NONE) ? S_ONE : S_SCAN;
							ebt_pkg::OP_CANDIDATE: state_q <= S_CRD;
							ebt_pkg::OP_DISPATCH: state_q <= S_DSCAN;
							default: state_q <= S_ONE;
						endcase
					end
				end
				S_SCAN: begin
					// last read is evaluated in the cycle after its issue
					if (scan_q == CW'(ebt_pkg::SLOTS)) begin
						state_q <= S_PICK;
					end else begin
						scan_q <= scan_q + CW'(1);
					end
				end
				S_PICK: begin
					if (out_free) begin
						out_valid_q <= 1'b1; last_q <= 1'b1; freed_q <= 1'b0;
						rbody_q <= '0; slot_q <= '0; gen_q <= '0;
						if (!tgt_found) begin
							status_q <= (op_q == ebt_pkg::OP_REGISTER) ?
								ebt_pkg::ST_CAPACITY : ebt_pkg::ST_NOTFOUND;
						end else if (!ok_q) begin
							status_q <= ebt_pkg::ST_PLATFORM;
							slot_q <= 4'(tgt_idx);
							gen_q <= tgt_gen;
						end else begin
							status_q <= ebt_pkg::ST_OK;
							slot_q <= 4'(tgt_idx);
							gen_q <= tgt_gen + 16'd1;
							pend_q[tgt_idx] <= 1'b0;
							if (op_q == ebt_pkg::OP_CANCEL) begin
								active_q <= active_q - CW'(1);
							end else if (!mfound_q) begin
								active_q <= active_q + CW'(1);
							end
						end
						state_q <= S_IDLE;
					end
				end
				S_CRD: state_q <= S_CEV;
				S_CEV: begin
					if (out_free) begin
						out_valid_q <= 1'b1; last_q <= 1'b1; freed_q <= 1'b0;
						rbody_q <= '0;
						// dropped-event count moves with the result it belongs to
						ovf_q <= ovf_q + add_q;
						if (!in_range) begin
							status_q <= ebt_pkg::ST_DROPPED;
							slot_q <= '0;
							gen_q <= '0;
						end else begin
							status_q <= drop ? ebt_pkg::ST_DROPPED : ebt_pkg::ST_OK;
							slot_q <= 4'(cidx_lo);
							gen_q <= ent.gen;
							if (!drop) begin
								pend_q[cidx_lo] <= 1'b1;
							end
						end
						state_q <= S_IDLE;
					end
				end
				S_DSCAN: begin
					if (scan_q == CW'(ebt_pkg::SLOTS) ||
							nres_q == ebt_pkg::RES_W'(ebt_pkg::MAX_RES)) begin
						state_q <= (nres_q == '0) ? S_ONE : S_IDLE;
					end else if (pend_q[scan_idx]) begin
						state_q <= S_DEV;
					end else begin
						scan_q <= scan_q + CW'(1);
					end
				end
				S_DEV: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q <= ebt_pkg::ST_OK;
						slot_q <= 4'(idx_s1);
						gen_q <= is_after ? ent.gen + 16'd1 : ent.gen;
						rbody_q <= ent.body;
						freed_q <= is_after;
						last_q <= (nres_q == ebt_pkg::RES_W'(ebt_pkg::MAX_RES - 1)) || !more_pend;
						pend_q[idx_s1] <= 1'b0;
						if (is_after) begin
							active_q <= active_q - CW'(1);
						end
						nres_q <= nres_q + ebt_pkg::RES_W'(1);
						scan_q <= scan_q + CW'(1);
						state_q <= S_DSCAN;
					end
				end
				S_ONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1; last_q <= 1'b1; freed_q <= 1'b0;
						rbody_q <= '0; slot_q <= '0; gen_q <= '0;
						if (op_q == ebt_pkg::OP_CLEAR) begin
							status_q <= (active_q != '0 && !ok_q) ?
								ebt_pkg::ST_PLATFORM : ebt_pkg::ST_OK;
							vld_q <= '0;
							pend_q <= '0;
							active_q <= '0;
							ovf_q <= '0;
						end else if (op_q == ebt_pkg::OP_DISPATCH) begin
							status_q <= ebt_pkg::ST_NOTHING;
						end else begin
							status_q <= ebt_pkg::ST_INVALID;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign slot = slot_q;
	assign tag_generation = gen_q;
	assign run_body = rbody_q;
	assign oneshot_freed = freed_q;
	assign active_bindings = 5'(active_q);
	assign overflow_total = ovf_q;
	assign last = last_q;

	a_active_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q <= CW'(ebt_pkg::SLOTS))
		else $error("active count above slot count");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while another is in work");

	a_pend_written: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q & ~vld_q) == '0)
		else $error("pending slot never written");

	a_nothing_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ebt_pkg::ST_NOTHING |-> last_q && !freed_q)
		else $error("idle dispatch result not final");

endmodule

// ===== rtl/ebt_ram.sv =====
module ebt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
